/* rtl/core/wsp_dist_pkg.sv */
// Shared types and constants for the wheel sync PID distance core.
// Used by the core and its port checker; depends on nothing.
`timescale 1ns / 1ps

package wsp_dist_pkg;

  // encoder delta and distance widths
  localparam int DELTA_BITS = 16;
  localparam int DIST_BITS  = 25;

  localparam int SPEED_W = 16;   // Q2.14
  localparam int GAIN_W  = 24;   // Q8.16
  localparam int TGT_W   = 24;
  localparam int LIM_W   = 15;
  localparam int INTEG_W = 32;

  localparam int ERR_W   = DELTA_BITS + 1;
  localparam int P_W     = GAIN_W + ERR_W;
  localparam int I_W     = GAIN_W + INTEG_W;
  localparam int ACC_W   = I_W + 3;
  localparam int TOT_W   = ((DIST_BITS > DELTA_BITS) ? DIST_BITS : DELTA_BITS) + 1;
  localparam int CMP_W   = (DIST_BITS > TGT_W) ? DIST_BITS : TGT_W;

  localparam int CFG_DW  = 32;
  localparam int CFG_AW  = 5;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(6554);

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    REG_BASE   = 3'd0,
    REG_PGAIN  = 3'd1,
    REG_IGAIN  = 3'd2,
    REG_DGAIN  = 3'd3,
    REG_TARGET = 3'd4,
    REG_LIMIT  = 3'd5
  } reg_idx_e;

  // how the result of one item is assembled at the output stage
  typedef struct packed {
    logic pid;         // left speed from the PID sum
    logic left_base;   // else left speed is base (1) or zero (0)
    logic apply;       // apply flag when not from PID
    logic right_base;  // right speed is base (1) or zero (0)
    logic done;
  } res_ctl_t;

endpackage

/* rtl/core/wheel_sync_pid_distance_core.sv */
// Wheel speed matching PID with distance stop: config registers, state and pipeline.
// Depends on wsp_dist_pkg.
//
//  channel | direction | handshake                     | payload
//  --------+-----------+-------------------------------+--------------------------------
//  in      | sink      | in_valid_i / in_stall_o       | mode_i, left_delta_i, right_delta_i
//  out     | source    | out_valid_o / out_stall_i     | left_speed_o, left_speed_apply_o,
//          |           |                               | right_speed_o, done_res_o
//  cfg     | sink      | APB psel/penable/pwrite       | paddr, pwdata, prdata
//
// One item is accepted per cycle unless the pipeline stalls; its result then passes the
// PID-term, product, sum and output registers. Integral, distance and previous-left state
// are updated in the first stage, whose update loop sets the rate; later stages multiply and sum.
// Reset clears state, configuration (limit to 0.4) and all stage valids.
// A stalled output holds; earlier stages keep filling until the pipeline is full.
`timescale 1ns / 1ps

module wheel_sync_pid_distance_core
  import wsp_dist_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   mode_i,
  input  logic signed [DELTA_BITS-1:0] left_delta_i,
  input  logic signed [DELTA_BITS-1:0] right_delta_i,

  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [SPEED_W-1:0]    left_speed_o,
  output logic                         left_speed_apply_o,
  output logic signed [SPEED_W-1:0]    right_speed_o,
  output logic                         done_res_o,

  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_AW-1:0]            paddr,
  input  logic [CFG_DW-1:0]            pwdata,
  output logic [CFG_DW-1:0]            prdata,
  output logic                         pready
);

  // ---------------- configuration ----------------
  logic signed [SPEED_W-1:0] base_q;
  logic signed [GAIN_W-1:0]  p_gain_q, i_gain_q, d_gain_q;
  logic [TGT_W-1:0]          target_q;
  logic [LIM_W-1:0]          limit_q;
  logic                      cfg_we;
  logic [2:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      p_gain_q <= '0;
      i_gain_q <= '0;
      d_gain_q <= '0;
      target_q <= '0;
      limit_q  <= LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_BASE:   base_q   <= pwdata[SPEED_W-1:0];
        REG_PGAIN:  p_gain_q <= pwdata[GAIN_W-1:0];
        REG_IGAIN:  i_gain_q <= pwdata[GAIN_W-1:0];
        REG_DGAIN:  d_gain_q <= pwdata[GAIN_W-1:0];
        REG_TARGET: target_q <= pwdata[TGT_W-1:0];
        REG_LIMIT:  limit_q  <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BASE:   prdata = CFG_DW'(unsigned'(base_q));
      REG_PGAIN:  prdata = CFG_DW'(unsigned'(p_gain_q));
      REG_IGAIN:  prdata = CFG_DW'(unsigned'(i_gain_q));
      REG_DGAIN:  prdata = CFG_DW'(unsigned'(d_gain_q));
      REG_TARGET: prdata = CFG_DW'(target_q);
      REG_LIMIT:  prdata = CFG_DW'(limit_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- stage handshake ----------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q, out_valid_q;
  logic out_ready, s4_ready, s3_ready, s2_ready, s1_ready;

  assign out_ready = !out_valid_q || !out_stall_i;
  assign s4_ready  = !s4_valid_q  || out_ready;
  assign s3_ready  = !s3_valid_q  || s4_ready;
  assign s2_ready  = !s2_valid_q  || s3_ready;
  assign s1_ready  = !s1_valid_q  || s2_ready;
  assign in_stall_o  = !s1_ready;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready)  s1_valid_q  <= in_valid_i;
      if (s2_ready)  s2_valid_q  <= s1_valid_q;
      if (s3_ready)  s3_valid_q  <= s2_valid_q;
      if (s4_ready)  s4_valid_q  <= s3_valid_q;
      if (out_ready) out_valid_q <= s4_valid_q;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic [1:0]                   s1_mode_q;
  logic signed [DELTA_BITS-1:0] s1_left_q, s1_right_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_ready) begin
      s1_mode_q  <= mode_i;
      s1_left_q  <= left_delta_i;
      s1_right_q <= right_delta_i;
    end
  end

  // ---------------- state update ----------------
  logic signed [INTEG_W-1:0] integ_q, integ_d;
  logic [DELTA_BITS-1:0]     prev_q, prev_d;
  logic [DIST_BITS-1:0]      total_q, total_d;
  logic                      fin_q, fin_d;

  logic [DELTA_BITS-1:0]     lmag, rmag;
  logic signed [ERR_W-1:0]   err, deriv;
  logic signed [INTEG_W:0]   integ_sum;
  logic signed [INTEG_W-1:0] integ_new;
  logic [TOT_W-1:0]          total_sum;
  logic [DIST_BITS-1:0]      total_new;
  logic                      finish_now;
  res_ctl_t                  ctl_d;
  logic                      s1_fire;

  assign s1_fire = s1_valid_q && s2_ready;

  always_comb begin
    // magnitude of the most negative delta wraps to the right unsigned value
    lmag  = s1_left_q[DELTA_BITS-1]  ? DELTA_BITS'(-s1_left_q)  : DELTA_BITS'(s1_left_q);
    rmag  = s1_right_q[DELTA_BITS-1] ? DELTA_BITS'(-s1_right_q) : DELTA_BITS'(s1_right_q);
    err   = signed'({1'b0, rmag}) - signed'({1'b0, lmag});
    deriv = signed'({1'b0, lmag}) - signed'({1'b0, prev_q});

    integ_sum = (INTEG_W+1)'(integ_q) + (INTEG_W+1)'(err);
    if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
      integ_new = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                     : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_new = integ_sum[INTEG_W-1:0];
    end

    total_sum = TOT_W'(total_q) + TOT_W'(rmag);
    if (total_sum[TOT_W-1:DIST_BITS] != '0) begin
      total_new = '1;
    end else begin
      total_new = total_sum[DIST_BITS-1:0];
    end
    finish_now = CMP_W'(total_new) > CMP_W'(target_q);
  end

  always_comb begin
    integ_d = integ_q;
    prev_d  = prev_q;
    total_d = total_q;
    fin_d   = fin_q;
    // status result by default
    ctl_d   = '{pid: 1'b0, left_base: 1'b0, apply: 1'b0, right_base: !fin_q, done: fin_q};
    unique case (s1_mode_q)
      MODE_START: begin
        total_d = '0;
        prev_d  = '0;
        fin_d   = 1'b0;
        ctl_d   = '{pid: 1'b0, left_base: 1'b1, apply: 1'b1, right_base: 1'b1, done: 1'b0};
      end
      MODE_CLEAR: begin
        integ_d = '0;
      end
      MODE_TICK: begin
        if (fin_q) begin
          ctl_d = '{pid: 1'b0, left_base: 1'b0, apply: 1'b0, right_base: 1'b0, done: 1'b1};
        end else begin
          integ_d = integ_new;
          prev_d  = lmag;
          total_d = total_new;
          if (finish_now) begin
            fin_d = 1'b1;
            ctl_d = '{pid: 1'b0, left_base: 1'b0, apply: 1'b1, right_base: 1'b0, done: 1'b1};
          end else begin
            ctl_d = '{pid: 1'b1, left_base: 1'b0, apply: 1'b0, right_base: 1'b1, done: 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
      total_q <= '0;
      fin_q   <= 1'b0;
    end else if (s1_fire) begin
      integ_q <= integ_d;
      prev_q  <= prev_d;
      total_q <= total_d;
      fin_q   <= fin_d;
    end
  end

  // ---------------- stage 2: PID terms ----------------
  logic signed [ERR_W-1:0]   s2_err_q, s2_deriv_q;
  logic signed [INTEG_W-1:0] s2_integ_q;
  res_ctl_t                  s2_ctl_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_err_q   <= err;
      s2_deriv_q <= deriv;
      s2_integ_q <= integ_new;
      s2_ctl_q   <= ctl_d;
    end
  end

  // ---------------- stage 3: products ----------------
  logic signed [P_W-1:0] s3_p_q, s3_d_q;
  logic signed [I_W-1:0] s3_i_q;
  res_ctl_t              s3_ctl_q;

  always_ff @(posedge clk_i) begin
    if (s2_valid_q && s3_ready) begin
      s3_p_q   <= p_gain_q * s2_err_q;
      s3_i_q   <= i_gain_q * s2_integ_q;
      s3_d_q   <= d_gain_q * s2_deriv_q;
      s3_ctl_q <= s2_ctl_q;
    end
  end

  // ---------------- stage 4: Q.16 sum with rounding offset ----------------
  logic signed [ACC_W-1:0] s4_acc_q;
  res_ctl_t                s4_ctl_q;

  always_ff @(posedge clk_i) begin
    if (s3_valid_q && s4_ready) begin
      s4_acc_q <= (ACC_W'(base_q) <<< 2) + ACC_W'(s3_p_q) + ACC_W'(s3_i_q)
                + ACC_W'(s3_d_q) + ACC_W'(2);
      s4_ctl_q <= s3_ctl_q;
    end
  end

  // ---------------- output stage: scale, saturate, limit check ----------------
  logic signed [ACC_W-1:0]   acc_q14;
  logic signed [SPEED_W-1:0] speed_sat, left_d, right_d;
  logic signed [SPEED_W:0]   speed_x, lim_x;
  logic                      apply_d;

  localparam logic signed [ACC_W-1:0] SPD_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SPD_MIN = -ACC_W'(32768);

  always_comb begin
    // arithmetic shift floors, so the +2 gives round half up
    acc_q14 = s4_acc_q >>> 2;
    priority if (acc_q14 > SPD_MAX) begin
      speed_sat = {1'b0, {(SPEED_W-1){1'b1}}};
    end else if (acc_q14 < SPD_MIN) begin
      speed_sat = {1'b1, {(SPEED_W-1){1'b0}}};
    end else begin
      speed_sat = acc_q14[SPEED_W-1:0];
    end
    speed_x = (SPEED_W+1)'(speed_sat);
    lim_x   = signed'((SPEED_W+1)'(limit_q));

    if (s4_ctl_q.pid) begin
      left_d  = speed_sat;
      apply_d = (speed_x < lim_x) && (speed_x > -lim_x);
    end else begin
      left_d  = s4_ctl_q.left_base ? base_q : '0;
      apply_d = s4_ctl_q.apply;
    end
    right_d = s4_ctl_q.right_base ? base_q : '0;
  end

  always_ff @(posedge clk_i) begin
    if (s4_valid_q && out_ready) begin
      left_speed_o       <= left_d;
      left_speed_apply_o <= apply_d;
      right_speed_o      <= right_d;
      done_res_o         <= s4_ctl_q.done;
    end
  end

endmodule

/* rtl/core/wsp_dist_checker.sv */
// Port-level checks for the wheel sync PID distance core, bound to the core module.
// Depends on wsp_dist_pkg and wheel_sync_pid_distance_core.
`timescale 1ns / 1ps

module wsp_dist_assert
  import wsp_dist_pkg::*;
(
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic signed [SPEED_W-1:0]    left_speed_o,
  input logic                         left_speed_apply_o,
  input logic signed [SPEED_W-1:0]    right_speed_o,
  input logic                         done_res_o
);

  // a finished run stops both motors
  a_done_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> (left_speed_o == '0) && (right_speed_o == '0))
    else $error("done item with nonzero speed");

  // with the output empty every stage can take an item
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output stage empty");

  a_valid_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_payload_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(left_speed_o) && $stable(left_speed_apply_o)
                                   && $stable(right_speed_o) && $stable(done_res_o))
    else $error("stalled result changed");

endmodule

bind wheel_sync_pid_distance_core wsp_dist_assert u_wsp_dist_assert (.*);
